### rtl/fou_pkg.sv
// Package: shared constants, types and the incremental checksum helper.
`timescale 1ns / 1ps
`default_nettype none
package fou_pkg;
  localparam int unsigned PosW          = 14;
  localparam int unsigned MaxFrameBytes = 16383;
  localparam int unsigned BurstMax      = 16;
  localparam int unsigned CntW          = 5;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [1:0] VerdictFwd   = 2'd0;
  localparam logic [1:0] VerdictShort = 2'd1;
  localparam logic [1:0] VerdictProto = 2'd2;

  typedef logic [7:0] byte_t;

  // Header length in 32-bit words, values below five taken as five.
  function automatic logic [3:0] eff_words(input logic [3:0] w);
    eff_words = (w < 4'd5) ? 4'd5 : w;
  endfunction

  // Ones-complement checksum update for a 32-bit field change.
  function automatic logic [15:0] csum_update(input logic [15:0] hc,
                                              input logic [31:0] oldv,
                                              input logic [31:0] newv);
    logic [18:0] s;
    logic [16:0] f;
    logic [15:0] g;
    s = {3'b0, ~hc} + {3'b0, ~oldv[31:16]} + {3'b0, ~oldv[15:0]}
      + {3'b0, newv[31:16]} + {3'b0, newv[15:0]};
    f = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    g = f[15:0] + {15'b0, f[16]};
    csum_update = ~g;
  endfunction
endpackage
`default_nettype wire

### rtl/fou_decap_rewriter_core.sv
// Top level: FOU decapsulation rewriter with output burst register.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, data_byte_i, frame_end_i | frame bytes in
//  out     | out_valid_o/out_ready_i, out_byte_o, out_end_o, verdict_o | bytes out
//
// Each input beat is processed in the cycle it is accepted; its results
// (0, 1, 2, 12 or 16 bytes) load a shift register that drains one beat a cycle
// while out_ready_i is high. A new input beat is taken whenever that register is
// empty or its last beat leaves, so unstalled byte streams run at one beat a cycle;
// MAC, inner header and checksum bursts hold the input until their last beat leaves.
// Reset is asynchronous and clears the control and frame state registers.
`timescale 1ns / 1ps
`default_nettype none
module fou_decap_rewriter_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_end_o,
  output logic [1:0]      verdict_o
);
  localparam int unsigned PW = fou_pkg::PosW;
  localparam int unsigned CW = fou_pkg::CntW;
  localparam int unsigned BN = fou_pkg::BurstMax;

  // frame state
  logic [PW-1:0]  pos_q, pos_d;
  fou_pkg::byte_t mac_q [12];
  fou_pkg::byte_t ibuf_q [16];
  logic [3:0]     ow_q, ow_d, iw_q, iw_d;
  logic [31:0]    odst_q, odst_d, osrc_q, osrc_d;
  logic [7:0]     proto_q, proto_d, chi_q, chi_d;
  logic [1:0]     fv_q, fv_d;

  // output burst register
  fou_pkg::byte_t obuf_q [BN];
  fou_pkg::byte_t nb_d [BN];
  logic [CW-1:0]  cnt_q, n_d;
  logic           end_q, end_d;
  logic [1:0]     vq_q, v_d;

  logic accept, out_fire;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CW'(1)) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;

  assign out_byte_o = obuf_q[0];
  assign out_end_o  = (cnt_q == CW'(1)) && end_q;
  assign verdict_o  = out_end_o ? vq_q : fou_pkg::VerdictFwd;

  // header offsets, checksums and verdict
  logic [PW-1:0] in_start, l4, chi, len_need;
  logic [PW:0]   len;
  logic [3:0]    k;
  logic          good_proto, is_udp;
  logic [15:0]   ip_nc, l4_hc, l4_nc;
  logic [31:0]   src_new;
  logic [1:0]    v;

  always_comb begin
    is_udp     = (proto_q == fou_pkg::ProtoUdp);
    good_proto = is_udp || (proto_q == fou_pkg::ProtoTcp);
    in_start   = PW'(22) + {{(PW-6){1'b0}}, fou_pkg::eff_words(ow_q), 2'b00};
    l4         = in_start + {{(PW-6){1'b0}}, fou_pkg::eff_words(iw_q), 2'b00};
    chi        = l4 + (is_udp ? PW'(6) : PW'(16));
    len_need   = l4 + (is_udp ? PW'(8) : PW'(20));
    len        = {1'b0, pos_q} + (PW+1)'(1);
    k          = pos_q[3:0] - in_start[3:0];
    src_new    = {ibuf_q[12], ibuf_q[13], ibuf_q[14], data_byte_i};
    ip_nc      = fou_pkg::csum_update({ibuf_q[10], ibuf_q[11]}, src_new, odst_q);
    l4_hc      = {chi_q, data_byte_i};
    l4_nc      = fou_pkg::csum_update(l4_hc, osrc_q, odst_q);
    if (is_udp && l4_hc == 16'h0000) begin
      l4_nc = 16'h0000;
    end else if (is_udp && l4_nc == 16'h0000) begin
      l4_nc = 16'hFFFF;
    end
    if (len < {1'b0, in_start + PW'(20)}) begin
      v = fou_pkg::VerdictShort;
    end else if (!good_proto) begin
      v = fou_pkg::VerdictProto;
    end else if (len < {1'b0, len_need}) begin
      v = fou_pkg::VerdictShort;
    end else begin
      v = fou_pkg::VerdictFwd;
    end
  end

  // per-beat processing
  always_comb begin
    pos_d   = pos_q;
    ow_d    = ow_q;
    iw_d    = iw_q;
    odst_d  = odst_q;
    osrc_d  = osrc_q;
    proto_d = proto_q;
    chi_d   = chi_q;
    fv_d    = fv_q;
    n_d     = '0;
    end_d   = 1'b0;
    v_d     = fou_pkg::VerdictFwd;
    for (int i = 0; i < BN; i++) nb_d[i] = '0;

    if (pos_q < PW'(12)) begin
      if (pos_q == PW'(11)) begin
        for (int i = 0; i < 5; i++) nb_d[i] = mac_q[6+i];
        nb_d[5] = data_byte_i;
        for (int i = 0; i < 6; i++) nb_d[6+i] = mac_q[i];
        n_d = CW'(12);
      end
    end else if (pos_q < PW'(14)) begin
      nb_d[0] = data_byte_i;
      n_d     = CW'(1);
    end else if (pos_q < in_start) begin
      if (pos_q == PW'(14)) ow_d = data_byte_i[3:0];
      if (pos_q >= PW'(30) && pos_q < PW'(34)) odst_d = {odst_q[23:0], data_byte_i};
    end else if (pos_q < in_start + PW'(16)) begin
      if (k == 4'd0) iw_d = data_byte_i[3:0];
      if (k == 4'd9) proto_d = data_byte_i;
      if (k == 4'd15) begin
        osrc_d = src_new;
        if (!good_proto) begin
          fv_d = fou_pkg::VerdictProto;
        end else begin
          for (int i = 0; i < 10; i++) nb_d[i] = ibuf_q[i];
          nb_d[10] = ip_nc[15:8];
          nb_d[11] = ip_nc[7:0];
          nb_d[12] = odst_q[31:24];
          nb_d[13] = odst_q[23:16];
          nb_d[14] = odst_q[15:8];
          nb_d[15] = odst_q[7:0];
          n_d      = CW'(16);
        end
      end
    end else if (fv_q == fou_pkg::VerdictFwd && good_proto) begin
      if (pos_q == chi) begin
        chi_d = data_byte_i;
      end else if (pos_q == chi + PW'(1)) begin
        nb_d[0] = l4_nc[15:8];
        nb_d[1] = l4_nc[7:0];
        n_d     = CW'(2);
      end else begin
        nb_d[0] = data_byte_i;
        n_d     = CW'(1);
      end
    end

    if (pos_q < PW'(fou_pkg::MaxFrameBytes)) pos_d = pos_q + PW'(1);

    // frame end: mark the last beat with the status (a lone zero byte if dropped or empty), clear frame state registers
    if (frame_end_i) begin
      if (v != fou_pkg::VerdictFwd || n_d == '0) begin
        for (int i = 0; i < BN; i++) nb_d[i] = '0;
        n_d = CW'(1);
      end
      end_d   = 1'b1;
      v_d     = v;
      pos_d   = '0;
      ow_d    = '0;
      iw_d    = '0;
      odst_d  = '0;
      osrc_d  = '0;
      proto_d = '0;
      chi_d   = '0;
      fv_d    = '0;
    end
  end

  // control and frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ow_q    <= '0;
      iw_q    <= '0;
      odst_q  <= '0;
      osrc_q  <= '0;
      proto_q <= '0;
      chi_q   <= '0;
      fv_q    <= '0;
      cnt_q   <= '0;
      end_q   <= 1'b0;
      vq_q    <= '0;
    end else begin
      if (accept) begin
        pos_q   <= pos_d;
        ow_q    <= ow_d;
        iw_q    <= iw_d;
        odst_q  <= odst_d;
        osrc_q  <= osrc_d;
        proto_q <= proto_d;
        chi_q   <= chi_d;
        fv_q    <= fv_d;
        cnt_q   <= n_d;
        end_q   <= end_d;
        vq_q    <= v_d;
      end else if (out_fire) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // payload storage: header buffers and the output shift register
  always_ff @(posedge clk_i) begin
    if (accept && pos_q < PW'(12)) mac_q[pos_q[3:0]] <= data_byte_i;
    if (accept && pos_q >= in_start && pos_q < in_start + PW'(16)) ibuf_q[k] <= data_byte_i;
    if (accept) begin
      for (int i = 0; i < BN; i++) obuf_q[i] <= nb_d[i];
    end else if (out_fire) begin
      for (int i = 0; i < BN - 1; i++) obuf_q[i] <= obuf_q[i+1];
      obuf_q[BN-1] <= '0;
    end
  end
endmodule
`default_nettype wire

### rtl/fou_checker.sv
// Checker: port-level properties of the rewriter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fou_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_end_o,
  input wire logic [1:0] verdict_o
);
  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_end_o))
    else $error("output beat changed while stalled");

  // status only rides on the closing beat
  a_verdict_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != fou_pkg::VerdictFwd |-> out_end_o)
    else $error("verdict without frame end");

  // no unused status code
  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o <= fou_pkg::VerdictProto)
    else $error("bad verdict code");

  // input is open whenever the output side is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // a dropped frame closes with a zero byte
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != fou_pkg::VerdictFwd |-> out_byte_o == 8'd0)
    else $error("drop beat carries data");
endmodule

bind fou_decap_rewriter_core fou_checker u_fou_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_end_o   (out_end_o),
  .verdict_o   (verdict_o)
);
`default_nettype wire
